// ===== rtl/chp_pkg.sv =====
// Shared constants and types for the convex hull perimeter core.
package chp_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int COORD_W    = 16;
  localparam int PT_W       = 2 * COORD_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int D2_W       = PROD_W + 1;
  localparam int FRAC_BITS  = 8;
  localparam int SQ_IN_W    = 52;
  localparam int SQ_STEPS   = SQ_IN_W / 2;
  localparam int SQ_CNT_W   = 5;
  localparam int ROOT_W     = 26;
  localparam int REM_W      = 28;
  localparam int PERIM_W    = 26;
  localparam logic [PERIM_W:0] PERIM_MAX = (27'd1 << PERIM_W) - 27'd1;

  typedef enum logic [2:0] {
    MS_AX_BY = 3'd0,
    MS_AY_BX = 3'd1,
    MS_AX_AX = 3'd2,
    MS_AY_AY = 3'd3,
    MS_BX_BX = 3'd4,
    MS_BY_BY = 3'd5
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRD,
    S_SCMP,
    S_RD,
    S_DIF,
    S_MUL,
    S_SUM,
    S_DEC,
    S_EDF,
    S_EMUL,
    S_ED,
    S_SQ,
    S_ACC,
    S_DONE
  } state_t;

endpackage

// ===== rtl/chp_point_if.sv =====
// Point request channel: valid, ready and one input point.
interface chp_point_if;
  import chp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      is_last;
  modport source (output valid, point_x, point_y, is_last, input ready);
  modport sink   (input valid, point_x, point_y, is_last, output ready);
endinterface

// ===== rtl/chp_result_if.sv =====
// Result request channel: valid, ready and the perimeter result.
interface chp_result_if;
  import chp_pkg::*;
  logic               valid;
  logic               ready;
  logic [PERIM_W-1:0] perimeter;
  logic               truncated;
  modport source (output valid, perimeter, truncated, input ready);
  modport sink   (input valid, perimeter, truncated, output ready);
endinterface

// ===== rtl/convex_hull_perimeter_core.sv =====
// Convex hull perimeter by gift wrapping over a stored point set.
// A point without the last mark is stored, and the core stays ready for more.
// The last point starts the wrap: one scan finds the start, one per hull vertex
// follows (one shared multiplier, six products per scanned point, 26-step root).
// Synchronous reset empties the point set; the point RAM itself is not cleared.
// A result waiting on its output does not block the loading of new points.
module convex_hull_perimeter_core
  import chp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  chp_point_if.sink    pts,
  chp_result_if.source res
);

  state_t state, state_next;

  logic [CNT_W-1:0]  cnt;
  logic              ovf;
  logic              trunc;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  steps;
  logic [IDX_W-1:0]  start_idx;
  logic [IDX_W-1:0]  nxt_idx;
  logic [2:0]        k;
  logic [SQ_CNT_W-1:0] sq_cnt;

  logic signed [COORD_W-1:0] sx, sy, cx, cy, nx, ny, px, py;
  logic signed [DIFF_W-1:0]  ax, ay, bx, by;
  logic signed [PROD_W-1:0]  p [6];
  logic signed [D2_W-1:0]    cr;
  logic [D2_W-1:0]           di, dn;
  logic [SQ_IN_W-1:0]        sq_val;
  logic [REM_W-1:0]          rem;
  logic [ROOT_W-1:0]         root;
  logic [PERIM_W-1:0]        sum;
  logic [PERIM_W-1:0]        perim;
  logic                      out_valid;

  logic [PT_W-1:0]           rdata;
  logic signed [COORD_W-1:0] rx, ry;
  logic                      ram_we;

  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [REM_W+1:0]          rem_sh, trial;
  logic [PERIM_W:0]          sum_ext;

  assign rx = rdata[COORD_W-1:0];
  assign ry = rdata[PT_W-1:COORD_W];

  assign pts.ready     = (state == S_IDLE);
  assign ram_we        = pts.valid && pts.ready && (cnt < CNT_W'(MAX_POINTS));
  assign res.valid     = out_valid;
  assign res.perimeter = perim;
  assign res.truncated = trunc;

  chp_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata ({pts.point_y, pts.point_x}),
    .raddr (idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  // The one multiplier; its operands come from the product select.
  always_comb begin
    mul_a = ax;
    mul_b = by;
    case (mul_sel_t'(k))
      MS_AX_BY: begin mul_a = ax; mul_b = by; end
      MS_AY_BX: begin mul_a = ay; mul_b = bx; end
      MS_AX_AX: begin mul_a = ax; mul_b = ax; end
      MS_AY_AY: begin mul_a = ay; mul_b = ay; end
      MS_BX_BX: begin mul_a = bx; mul_b = bx; end
      MS_BY_BY: begin mul_a = by; mul_b = by; end
      default:  begin mul_a = ax; mul_b = by; end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign rem_sh  = {rem, sq_val[SQ_IN_W-1 -: 2]};
  assign trial   = {2'b00, root, 2'b01};
  assign sum_ext = {1'b0, sum} + {1'b0, root};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!out_valid || res.ready)) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pts.valid) begin
            if (ram_we) begin
              cnt <= cnt + CNT_W'(1);
            end
            if (!ram_we) begin
              ovf <= 1'b1;
            end
            idx <= '0;
          end
        end
        S_SCMP: begin
          if (idx == '0) begin
            start_idx <= '0;
            sx <= rx; sy <= ry;
            nx <= rx; ny <= ry;
          end else if (sy > ry || (sy == ry && sx > rx)) begin
            start_idx <= idx[IDX_W-1:0];
            sx <= rx; sy <= ry;
          end
          if (idx + CNT_W'(1) == cnt) begin
            idx     <= '0;
            steps   <= '0;
            nxt_idx <= '0;
            sum     <= '0;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_RD: begin
          if (steps == '0 && idx == '0) begin
            cx <= sx; cy <= sy;
          end
        end
        S_DIF: begin
          px <= rx; py <= ry;
          ax <= DIFF_W'(rx) - DIFF_W'(cx);
          ay <= DIFF_W'(ry) - DIFF_W'(cy);
          bx <= DIFF_W'(nx) - DIFF_W'(cx);
          by <= DIFF_W'(ny) - DIFF_W'(cy);
          k  <= 3'(MS_AX_BY);
        end
        S_MUL, S_EMUL: begin
          p[k] <= prod;
          k    <= k + 3'd1;
        end
        S_SUM: begin
          cr <= D2_W'(p[0]) - D2_W'(p[1]);
          di <= D2_W'($unsigned(p[2])) + D2_W'($unsigned(p[3]));
          dn <= D2_W'($unsigned(p[4])) + D2_W'($unsigned(p[5]));
        end
        S_DEC: begin
          // Farther collinear point wins; an equal one found earlier stays.
          if ((!cr[D2_W-1] && cr != '0) || (cr == '0 && di > dn)) begin
            nxt_idx <= idx[IDX_W-1:0];
            nx <= px; ny <= py;
          end
          idx <= idx + CNT_W'(1);
        end
        S_EDF: begin
          bx <= DIFF_W'(nx) - DIFF_W'(cx);
          by <= DIFF_W'(ny) - DIFF_W'(cy);
          k  <= 3'(MS_BX_BX);
        end
        S_ED: begin
          sq_val <= {{(SQ_IN_W-D2_W-2*FRAC_BITS){1'b0}},
                     D2_W'($unsigned(p[4])) + D2_W'($unsigned(p[5])),
                     {(2*FRAC_BITS){1'b0}}};
          sq_cnt <= '0;
          rem    <= '0;
          root   <= '0;
        end
        S_SQ: begin
          sq_val <= {sq_val[SQ_IN_W-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem  <= REM_W'(rem_sh - trial);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= REM_W'(rem_sh);
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          sq_cnt <= sq_cnt + SQ_CNT_W'(1);
        end
        S_ACC: begin
          sum   <= (sum_ext > PERIM_MAX) ? PERIM_W'(PERIM_MAX) : sum_ext[PERIM_W-1:0];
          cx    <= nx; cy <= ny;
          steps <= steps + CNT_W'(1);
          idx   <= '0;
        end
        S_DONE: begin
          // The result registers change only when a new result is posted.
          if (!out_valid || res.ready) begin
            perim <= sum;
            trunc <= ovf;
            cnt   <= '0;
            ovf   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (pts.valid && pts.is_last) state_next = S_SRD;
      S_SRD:  state_next = S_SCMP;
      S_SCMP: state_next = (idx + CNT_W'(1) == cnt) ? S_RD : S_SRD;
      S_RD:   state_next = S_DIF;
      S_DIF:  state_next = S_MUL;
      S_MUL:  if (k == 3'(MS_BY_BY)) state_next = S_SUM;
      S_SUM:  state_next = S_DEC;
      S_DEC:  state_next = (idx + CNT_W'(1) == cnt) ? S_EDF : S_RD;
      S_EDF:  state_next = S_EMUL;
      S_EMUL: if (k == 3'(MS_BY_BY)) state_next = S_ED;
      S_ED:   state_next = S_SQ;
      S_SQ:   if (sq_cnt == SQ_CNT_W'(SQ_STEPS - 1)) state_next = S_ACC;
      S_ACC:  begin
        if (nxt_idx == start_idx || steps + CNT_W'(1) == cnt) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RD;
        end
      end
      S_DONE: if (!out_valid || res.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || res.ready)) |=> (cnt == '0 && !ovf && out_valid))
    else $error("point set not cleared when the result was posted");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> (steps < cnt))
    else $error("hull walk exceeded the step bound");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC || state == S_SCMP) |-> (idx < cnt))
    else $error("scan index beyond stored points");

endmodule

// ===== rtl/chp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module chp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
